FILE: hdl/hoc_pkg.sv
// hoc_pkg: word types and fixed-point constants of the humidity offset compensation block
// standalone, used by humidity_offset_compensation_top
`default_nettype none

package hoc_pkg;

	typedef struct packed {
		logic signed [10:0] raw_temp;
		logic [9:0]         raw_hum;
	} hoc_in_t;

	typedef struct packed {
		logic signed [10:0] corrected_temp;
		logic [9:0]         corrected_hum;
		logic [15:0]        abs_hum;
		logic               hum_clipped;
	} hoc_out_t;

	localparam logic [7:0]         OFFSET_RESET   = 8'd45;
	localparam logic signed [11:0] TC_FLOOR       = -12'sd1024;
	localparam logic [63:0]        Q30_ONE        = 64'd1073741824;
	localparam logic [63:0]        LN2_Q30        = 64'd744261118;
	localparam logic signed [18:0] LOG2_10_Q16    = 19'sd217706;
	localparam logic [29:0]        EXP_NUM2       = 30'd983040;
	localparam logic signed [12:0] EXP_DEN_BIAS   = 13'sd2373;
	localparam logic [21:0]        LOG2_LIMIT     = 22'd4128768;
	localparam logic [22:0]        LOG2_BIAS      = 23'd4194304;
	localparam logic [61:0]        ABS_CONST_Q16  = 62'd867288368;
	localparam logic signed [16:0] KELVIN_HUNDREDTHS = 17'sd27315;
	localparam logic [9:0]         HUM_MAX        = 10'd1000;
	localparam logic [15:0]        ABS_MAX        = 16'hFFFF;

endpackage

`default_nettype wire

FILE: hdl/humidity_offset_compensation_top.sv
// humidity_offset_compensation_top: offset-corrected temperature, rescaled humidity, absolute humidity
// depends on hoc_pkg and hoc_div
`default_nettype none

// One sample word enters per clock and one result word leaves per clock while the output
// is not stalled. The pipeline holds two pipelined dividers: the Tetens exponent divider
// (19 stages, one per quotient bit) and the absolute humidity divider (16 stages), plus the
// power-of-ten path around the 2^x table read. A stall on the output freezes the whole
// pipeline; in_stall is raised only while a finished word waits there.

module humidity_offset_compensation_top import hoc_pkg::*; #(
	parameter int POW_TABLE_DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic     in_valid,
	output logic     in_stall,
	input  hoc_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output hoc_out_t out_data
);

	localparam int IW = $clog2(POW_TABLE_DEPTH + 1);
	localparam int PW = 16 + IW;

	typedef logic [31:0] tab_t [POW_TABLE_DEPTH+1];

	function automatic tab_t build_tab();
		tab_t        tb;
		logic [63:0] y;
		logic [63:0] sum;
		logic [63:0] term;
		for (int k = 0; k < POW_TABLE_DEPTH; k++) begin
			y = (64'(k) * LN2_Q30) / 64'(POW_TABLE_DEPTH);
			sum = Q30_ONE;
			term = Q30_ONE;
			for (int n = 1; n <= 24; n++) begin
				term = ((term * y) >> 30) / 64'(n);
				sum = sum + term;
			end
			tb[k] = sum[31:0];
		end
		tb[POW_TABLE_DEPTH] = 32'h8000_0000;
		return tb;
	endfunction

	localparam tab_t POW_TAB = build_tab();

	function automatic logic [29:0] exp_num(input logic signed [10:0] t);
		logic [10:0]        mag;
		logic signed [12:0] ds;
		mag = t[10] ? 11'(-t) : 11'(t);
		ds = 13'(t) + EXP_DEN_BIAS;
		return 30'(mag) * EXP_NUM2 + 30'(ds[11:0]);
	endfunction

	function automatic logic [12:0] exp_den(input logic signed [10:0] t);
		logic signed [12:0] ds;
		ds = 13'(t) + EXP_DEN_BIAS;
		return {ds[11:0], 1'b0};
	endfunction

	// config and flow control
	logic [7:0] temp_offset_q;
	logic       adv;
	logic       out_valid_q;
	hoc_out_t   out_q;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_offset_q <= OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			temp_offset_q <= cfg_data;
		end
	end

	// stage 1: offset subtraction
	logic signed [11:0] tc_full;
	logic signed [10:0] tc_w;
	logic               vld_s1;
	logic signed [10:0] t0_s1, t1_s1;
	logic [9:0]         rh_s1;

	assign tc_full = {in_data.raw_temp[10], in_data.raw_temp} - $signed({4'b0, temp_offset_q});
	assign tc_w    = (tc_full < TC_FLOOR) ? TC_FLOOR[10:0] : tc_full[10:0];

	// exponent dividers
	logic        v_e0, v_e1;
	logic [18:0] q_e0, q_e1;
	logic [21:0] side_e0;
	logic        side_e1;

	hoc_div #(.NW(30), .DW(13), .QW(19), .SW(22)) u_div_e0 (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(vld_s1),
		.num(exp_num(t0_s1)), .den(exp_den(t0_s1)),
		.side({t1_s1, rh_s1, t0_s1[10]}),
		.out_vld(v_e0), .quo(q_e0), .side_out(side_e0)
	);

	hoc_div #(.NW(30), .DW(13), .QW(19), .SW(1)) u_div_e1 (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(vld_s1),
		.num(exp_num(t1_s1)), .den(exp_den(t1_s1)),
		.side(t1_s1[10]),
		.out_vld(v_e1), .quo(q_e1), .side_out(side_e1)
	);

	logic signed [19:0] e0_w, e1_w;
	assign e0_w = side_e0[0] ? -$signed({1'b0, q_e0}) : $signed({1'b0, q_e0});
	assign e1_w = side_e1 ? -$signed({1'b0, q_e1}) : $signed({1'b0, q_e1});

	// power of ten lanes: lane 0 for the exponent difference, lane 1 for the corrected exponent
	logic               vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic signed [20:0] e_s2    [2];
	logic signed [38:0] prod_s3 [2];
	logic [22:0]        lb_s4   [2];
	logic [6:0]         ip_s5   [2];
	logic [6:0]         ip_s6   [2];
	logic [6:0]         ip_s7   [2];
	logic [6:0]         ip_s8   [2];
	logic [IW-1:0]      j_s5    [2];
	logic [15:0]        r_s5    [2];
	logic [15:0]        r_s6    [2];
	logic [31:0]        lo_s6   [2];
	logic [31:0]        hi_s6   [2];
	logic [31:0]        lo_s7   [2];
	logic [46:0]        dr_s7   [2];
	logic [31:0]        m_s8    [2];
	logic signed [10:0] tc_s2, tc_s3, tc_s4, tc_s5, tc_s6, tc_s7, tc_s8;
	logic [9:0]         rh_s2, rh_s3, rh_s4, rh_s5, rh_s6, rh_s7, rh_s8;

	logic signed [38:0] prod_w [2];
	logic [22:0]        lb_w   [2];
	logic [PW-1:0]      p_w    [2];
	logic [31:0]        m_w    [2];

	always_comb begin
		logic [37:0] mag;
		logic [21:0] lm;
		for (int g = 0; g < 2; g++) begin
			prod_w[g] = e_s2[g] * LOG2_10_Q16;
			mag = prod_s3[g][38] ? 38'(-prod_s3[g]) : 38'(prod_s3[g]);
			lm = 22'((39'(mag) + 39'd32768) >> 16);
			if (lm > LOG2_LIMIT) begin
				lm = LOG2_LIMIT;
			end
			lb_w[g] = prod_s3[g][38] ? LOG2_BIAS - 23'(lm) : LOG2_BIAS + 23'(lm);
			p_w[g] = PW'(lb_s4[g][15:0]) * PW'(POW_TABLE_DEPTH);
			m_w[g] = lo_s7[g] + 32'((48'(dr_s7[g]) + 48'd32768) >> 16);
		end
	end

	// humidity rescale and absolute humidity
	logic               vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14, vld_s15;
	logic [41:0]        ph_s9;
	logic signed [7:0]  sh_s9;
	logic signed [7:0]  sa_s9, sa_s10, sa_s11;
	logic [21:0]        m20_s9, m20_s10;
	logic [15:0]        k100_s9, k100_s10, k100_s11, k100_s12, k100_s13, k100_s14, k100_s15;
	logic               rh_nz_s9;
	logic signed [10:0] tc_s9, tc_s10, tc_s11, tc_s12, tc_s13, tc_s14, tc_s15;
	logic [9:0]         h_s10, h_s11, h_s12, h_s13, h_s14, h_s15;
	logic               clip_s10, clip_s11, clip_s12, clip_s13, clip_s14, clip_s15;
	logic [31:0]        hm_s11;
	logic [61:0]        x_s12;
	logic [5:0]         a_s12;
	logic [5:0]         b_s12, b_s13;
	logic               lt1_s12;
	logic [63:0]        n_s13, ns_s14;
	logic               sat_s13, sat_s14, sat_s15;
	logic               zero_s13, zero_s14, zero_s15;
	logic [31:0]        num_s15;

	logic [41:0]        ph_w;
	logic signed [16:0] k_w;
	logic [21:0]        m20_w;
	logic [63:0]        hv;
	logic [5:0]         shv;
	logic               clip_w;
	logic [9:0]         h_w;
	logic [61:0]        x_w;
	logic [61:0]        np_w;
	logic [63:0]        n_w;
	logic               ovf_w;

	always_comb begin
		ph_w  = rh_s8 * m_s8[0];
		k_w   = 17'(tc_s8) * 17'sd10 + KELVIN_HUNDREDTHS;
		m20_w = 22'((33'(m_s8[1]) + 33'd512) >> 10);

		shv = sh_s9[5:0];
		if (sh_s9 < 8'sd1) begin
			hv = rh_nz_s9 ? 64'd1001 : 64'd0;
		end else if (sh_s9 > 8'sd62) begin
			hv = 64'd0;
		end else begin
			hv = (64'(ph_s9) + (64'd1 << (shv - 6'd1))) >> shv;
		end
		clip_w = hv > 64'(HUM_MAX);
		h_w    = clip_w ? HUM_MAX : hv[9:0];

		x_w   = hm_s11 * ABS_CONST_Q16;
		np_w  = x_s12 >> a_s12;
		n_w   = {1'b0, np_w, 1'b0} + (64'(k100_s12) << b_s12);
		ovf_w = (|ns_s14[63:32]) || (ns_s14[31:0] >= {k100_s14, 16'd0});
	end

	// absolute humidity divider
	logic        v_a;
	logic [15:0] q_a;
	logic [23:0] side_a;

	hoc_div #(.NW(32), .DW(16), .QW(16), .SW(24)) u_div_abs (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(vld_s15),
		.num(num_s15), .den(k100_s15),
		.side({tc_s15, h_s15, clip_s15, sat_s15, zero_s15}),
		.out_vld(v_a), .quo(q_a), .side_out(side_a)
	);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			vld_s7      <= 1'b0;
			vld_s8      <= 1'b0;
			vld_s9      <= 1'b0;
			vld_s10     <= 1'b0;
			vld_s11     <= 1'b0;
			vld_s12     <= 1'b0;
			vld_s13     <= 1'b0;
			vld_s14     <= 1'b0;
			vld_s15     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= in_valid;
			vld_s2      <= v_e0 & v_e1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= vld_s5;
			vld_s7      <= vld_s6;
			vld_s8      <= vld_s7;
			vld_s9      <= vld_s8;
			vld_s10     <= vld_s9;
			vld_s11     <= vld_s10;
			vld_s12     <= vld_s11;
			vld_s13     <= vld_s12;
			vld_s14     <= vld_s13;
			vld_s15     <= vld_s14;
			out_valid_q <= v_a;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			t0_s1 <= in_data.raw_temp;
			t1_s1 <= tc_w;
			rh_s1 <= in_data.raw_hum;

			e_s2[0] <= 21'(e0_w) - 21'(e1_w);
			e_s2[1] <= 21'(e1_w);
			tc_s2   <= side_e0[21:11];
			rh_s2   <= side_e0[10:1];

			for (int g = 0; g < 2; g++) begin
				prod_s3[g] <= prod_w[g];
				lb_s4[g]   <= lb_w[g];
				ip_s5[g]   <= lb_s4[g][22:16];
				j_s5[g]    <= p_w[g][PW-1:16];
				r_s5[g]    <= p_w[g][15:0];
				lo_s6[g]   <= POW_TAB[j_s5[g]];
				hi_s6[g]   <= POW_TAB[j_s5[g] + IW'(1)];
				r_s6[g]    <= r_s5[g];
				ip_s6[g]   <= ip_s5[g];
				dr_s7[g]   <= (hi_s6[g] - lo_s6[g]) * r_s6[g];
				lo_s7[g]   <= lo_s6[g];
				ip_s7[g]   <= ip_s6[g];
				m_s8[g]    <= m_w[g];
				ip_s8[g]   <= ip_s7[g];
			end
			tc_s3 <= tc_s2;
			tc_s4 <= tc_s3;
			tc_s5 <= tc_s4;
			tc_s6 <= tc_s5;
			tc_s7 <= tc_s6;
			tc_s8 <= tc_s7;
			rh_s3 <= rh_s2;
			rh_s4 <= rh_s3;
			rh_s5 <= rh_s4;
			rh_s6 <= rh_s5;
			rh_s7 <= rh_s6;
			rh_s8 <= rh_s7;

			ph_s9    <= ph_w;
			sh_s9    <= 8'sd94 - $signed({1'b0, ip_s8[0]});
			sa_s9    <= 8'sd100 - $signed({1'b0, ip_s8[1]});
			m20_s9   <= m20_w;
			k100_s9  <= k_w[15:0];
			rh_nz_s9 <= |rh_s8;
			tc_s9    <= tc_s8;

			h_s10    <= h_w;
			clip_s10 <= clip_w;
			m20_s10  <= m20_s9;
			sa_s10   <= sa_s9;
			k100_s10 <= k100_s9;
			tc_s10   <= tc_s9;

			hm_s11   <= 32'(h_s10) * 32'(m20_s10);
			sa_s11   <= sa_s10;
			k100_s11 <= k100_s10;
			tc_s11   <= tc_s10;
			h_s11    <= h_s10;
			clip_s11 <= clip_s10;

			x_s12    <= x_w;
			lt1_s12  <= sa_s11 < 8'sd1;
			a_s12    <= (sa_s11 > 8'sd40) ? 6'(sa_s11 - 8'sd40) : 6'd0;
			b_s12    <= (sa_s11 > 8'sd40) ? 6'd40 : sa_s11[5:0];
			k100_s12 <= k100_s11;
			tc_s12   <= tc_s11;
			h_s12    <= h_s11;
			clip_s12 <= clip_s11;

			n_s13    <= n_w;
			b_s13    <= b_s12;
			sat_s13  <= lt1_s12 && (|x_s12);
			zero_s13 <= lt1_s12 && !(|x_s12);
			k100_s13 <= k100_s12;
			tc_s13   <= tc_s12;
			h_s13    <= h_s12;
			clip_s13 <= clip_s12;

			ns_s14   <= n_s13 >> (7'(b_s13) + 7'd1);
			sat_s14  <= sat_s13;
			zero_s14 <= zero_s13;
			k100_s14 <= k100_s13;
			tc_s14   <= tc_s13;
			h_s14    <= h_s13;
			clip_s14 <= clip_s13;

			num_s15  <= (ovf_w || sat_s14 || zero_s14) ? 32'd0 : ns_s14[31:0];
			sat_s15  <= sat_s14 || ovf_w;
			zero_s15 <= zero_s14;
			k100_s15 <= k100_s14;
			tc_s15   <= tc_s14;
			h_s15    <= h_s14;
			clip_s15 <= clip_s14;

			out_q.corrected_temp <= side_a[23:13];
			out_q.corrected_hum  <= side_a[12:3];
			out_q.hum_clipped    <= side_a[2];
			out_q.abs_hum        <= side_a[1] ? ABS_MAX : (side_a[0] ? 16'd0 : q_a);
		end
	end

`ifndef SYNTHESIS
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		v_e0 == v_e1)
		else $error("exponent dividers out of step");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.hum_clipped |-> out_data.corrected_hum == HUM_MAX)
		else $error("clipped humidity not at full scale");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.corrected_hum <= HUM_MAX)
		else $error("corrected humidity above full scale");

	a_dry_air: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.corrected_hum == 10'd0 |->
			out_data.abs_hum == 16'd0 && !out_data.hum_clipped)
		else $error("nonzero absolute humidity at zero relative humidity");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> temp_offset_q == $past(cfg_data))
		else $error("offset register not written");
`endif

endmodule

`default_nettype wire

FILE: hdl/hoc_div.sv
// hoc_div: pipelined restoring divider, one quotient bit per stage, sideband carried along
// no package dependencies; numerator must be below den times 2^QW
`default_nettype none

module hoc_div #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int QW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic          out_vld,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);

	localparam int XW = (NW > DW + QW) ? NW : DW + QW;

	logic          vld_s  [QW];
	logic [NW-1:0] rem_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [SW-1:0] side_s [QW];

	logic          vld_i  [QW];
	logic [NW-1:0] rem_i  [QW];
	logic [DW-1:0] den_i  [QW];
	logic [QW-1:0] quo_i  [QW];
	logic [SW-1:0] side_i [QW];

	genvar k;
	for (k = 0; k < QW; k++) begin : g_stage
		logic [XW-1:0] rem_x;
		logic [XW-1:0] dsh;
		logic          ge;

		if (k == 0) begin : g_first
			assign vld_i[k]  = in_vld;
			assign rem_i[k]  = num;
			assign den_i[k]  = den;
			assign quo_i[k]  = '0;
			assign side_i[k] = side;
		end else begin : g_next
			assign vld_i[k]  = vld_s[k-1];
			assign rem_i[k]  = rem_s[k-1];
			assign den_i[k]  = den_s[k-1];
			assign quo_i[k]  = quo_s[k-1];
			assign side_i[k] = side_s[k-1];
		end

		assign rem_x = XW'(rem_i[k]);
		assign dsh   = XW'(den_i[k]) << (QW - 1 - k);
		assign ge    = rem_x >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k]  <= quo_i[k] | (QW'(ge) << (QW - 1 - k));
				side_s[k] <= side_i[k];
			end
		end

		if (k < QW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? NW'(rem_x - dsh) : rem_i[k];
					den_s[k] <= den_i[k];
				end
			end
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign quo      = quo_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

`default_nettype wire
